// ===== rtl/pbfm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfm_pkg
// Shared types and codes for the page buffer frame manager.
// ----------------------------------------------------------------------------
package pbfm_pkg;

  localparam int PID_W = 31;
  localparam int PIN_W = 8;
  localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;

  localparam logic [2:0] ACT_FETCH  = 3'd0;
  localparam logic [2:0] ACT_UNPIN  = 3'd1;
  localparam logic [2:0] ACT_NEW    = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_FLUSH  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOTRES  = 3'd1;
  localparam logic [2:0] ST_NOFRAME = 3'd2;
  localparam logic [2:0] ST_NOTPIN  = 3'd3;
  localparam logic [2:0] ST_SAT     = 3'd4;

  localparam logic [1:0] REL_NONE    = 2'd0;
  localparam logic [1:0] REL_ZERO    = 2'd1;
  localparam logic [1:0] REL_DEALLOC = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // in-place change of a resident frame
  typedef struct packed {
    logic             en;
    logic             valid;
    logic             dirty;
    logic [PIN_W-1:0] pins;
  } frame_mod_t;

  // install of a new page into a frame
  typedef struct packed {
    logic             en;
    logic             dirty;
    logic [PID_W-1:0] pid;
  } frame_load_t;

endpackage

// ===== rtl/pbfm_fcell.sv =====
// ----------------------------------------------------------------------------
// pbfm_fcell
// One frame: page id, valid, dirty, pin count, and its lookup compare.
// ----------------------------------------------------------------------------
module pbfm_fcell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pbfm_pkg::PID_W-1:0] key,
  input  logic                       mod_sel,
  input  pbfm_pkg::frame_mod_t       mod,
  input  logic                       load_sel,
  input  pbfm_pkg::frame_load_t      load,
  output logic                       match,
  output logic                       valid,
  output logic                       dirty,
  output logic [pbfm_pkg::PIN_W-1:0] pins,
  output logic [pbfm_pkg::PID_W-1:0] pid
);

  assign match = valid && (pid == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      pins  <= '0;
    end else if (load_sel) begin
      valid <= 1'b1;
      dirty <= load.dirty;
      pins  <= pbfm_pkg::PIN_W'(1);
    end else if (mod_sel) begin
      valid <= mod.valid;
      dirty <= mod.dirty;
      pins  <= mod.pins;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sel) begin
      pid <= load.pid;
    end
  end

endmodule

// ===== rtl/pbfm_qcell.sv =====
// ----------------------------------------------------------------------------
// pbfm_qcell
// One slot of an ordered frame queue; shifts toward the head on removal.
// ----------------------------------------------------------------------------
module pbfm_qcell #(
  parameter int         W       = 4,
  parameter logic [W-1:0] RST_VAL = '0,
  parameter logic       RST_OCC = 1'b0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] key,
  input  logic         key_rm,
  input  logic         seen_in,
  input  logic [W-1:0] nbr_val,
  input  logic         nbr_occ,
  input  logic         push_here,
  input  logic [W-1:0] push_val,
  output logic [W-1:0] val,
  output logic         occ,
  output logic         match,
  output logic         seen_out
);

  assign match    = occ && (val == key);
  assign seen_out = seen_in | (key_rm & match);

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= RST_VAL;
      occ <= RST_OCC;
    end else if (push_here) begin
      val <= push_val;
      occ <= 1'b1;
    end else if (seen_out) begin
      val <= nbr_val;
      occ <= nbr_occ;
    end
  end

endmodule

// ===== rtl/pbfm_queue.sv =====
// ----------------------------------------------------------------------------
// pbfm_queue
// Ordered list of frame numbers: pop head, remove by value, push at tail.
// ----------------------------------------------------------------------------
module pbfm_queue #(
  parameter int   N         = 16,
  parameter logic INIT_FULL = 1'b0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [$clog2(N)-1:0]       key,
  input  logic                       key_rm,
  input  logic                       pop,
  input  logic                       push,
  input  logic [$clog2(N)-1:0]       push_val,
  output logic                       found,
  output logic [$clog2(N)-1:0]       head,
  output logic [$clog2(N+1)-1:0]     count
);

  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);

  logic [IW-1:0] val [N];
  logic          occ [N];
  logic [N-1:0]  match;
  logic [N:0]    seen;
  logic [N-1:0]  push_here;
  logic          rm;
  logic [CW-1:0] tail;

  assign seen[0] = pop;
  assign rm      = seen[N];
  assign tail    = count - CW'(rm);
  assign found   = |match;
  assign head    = val[0];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      logic [IW-1:0] nv;
      logic          no;
      if (i < N - 1) begin : g_mid
        assign nv = val[i+1];
        assign no = occ[i+1];
      end else begin : g_last
        assign nv = '0;
        assign no = 1'b0;
      end
      assign push_here[i] = push && (tail == CW'(i));
      pbfm_qcell #(
        .W       (IW),
        .RST_VAL (INIT_FULL ? IW'(i) : IW'(0)),
        .RST_OCC (INIT_FULL)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .key       (key),
        .key_rm    (key_rm),
        .seen_in   (seen[i]),
        .nbr_val   (nv),
        .nbr_occ   (no),
        .push_here (push_here[i]),
        .push_val  (push_val),
        .val       (val[i]),
        .occ       (occ[i]),
        .match     (match[i]),
        .seen_out  (seen[i+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= INIT_FULL ? CW'(N) : CW'(0);
    end else begin
      count <= count - CW'(rm) + CW'(push);
    end
  end

endmodule

// ===== rtl/page_buffer_frame_manager.sv =====
// ----------------------------------------------------------------------------
// page_buffer_frame_manager
// Frame bookkeeping of a page cache: lookup, pin counts, FIFO free list and
// LRU order of unpinned frames, with disk commands per request.
// A request is captured in the idle state and its result is registered when
// the execute state completes; a new request is taken only in idle. The frame
// lookup and the queue updates of one request finish in its execute state.
// Reset: all frames free in order 0..POOL_FRAMES-1, LRU empty, no pins.
// ----------------------------------------------------------------------------
module page_buffer_frame_manager #(
  parameter int POOL_FRAMES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 action,
  input  logic [pbfm_pkg::PID_W-1:0] page_id,
  input  logic                       mark_dirty,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic [3:0]                 frame,
  output logic                       hit,
  output logic                       write_out,
  output logic [pbfm_pkg::PID_W-1:0] write_page_id,
  output logic                       load_from_disk,
  output logic                       zero_frame,
  output logic [1:0]                 disk_release
);

  localparam int FW = $clog2(POOL_FRAMES);
  localparam int CW = $clog2(POOL_FRAMES + 1);
  localparam int PW = pbfm_pkg::PIN_W;
  localparam int DW = pbfm_pkg::PID_W;

  pbfm_pkg::state_t state;

  logic [2:0]    act_q;
  logic [DW-1:0] pid_q;
  logic          mk_q;

  logic          c_match [POOL_FRAMES];
  logic          c_valid [POOL_FRAMES];
  logic          c_dirty [POOL_FRAMES];
  logic [PW-1:0] c_pins  [POOL_FRAMES];
  logic [DW-1:0] c_pid   [POOL_FRAMES];

  logic          f_hit;
  logic [FW-1:0] f_idx;
  logic [PW-1:0] pins_f;
  logic          dirty_f;
  logic [DW-1:0] pid_f;

  logic [FW-1:0] free_head, lru_head;
  logic [CW-1:0] free_cnt, lru_cnt;
  logic          free_found, lru_found;
  logic          fq_pop, fq_push, lq_rm, lq_pop, lq_push;

  logic          drop, from_free, take_ok, vic_wb;
  logic [FW-1:0] victim;

  pbfm_pkg::frame_mod_t  mod;
  pbfm_pkg::frame_load_t ld;
  logic [FW-1:0]         ld_idx;

  logic [2:0]    st;
  logic [FW-1:0] frm_idx;
  logic          o_hit, o_wo, o_load, o_zero;
  logic [DW-1:0] o_wpid;
  logic [1:0]    o_rel;
  logic [FW+3:0] frm_ext;

  logic exec_go;

  assign in_stall = (state != pbfm_pkg::S_IDLE);
  assign exec_go  = (state == pbfm_pkg::S_EXEC) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbfm_pkg::S_IDLE;
    end else begin
      case (state)
        pbfm_pkg::S_IDLE: if (in_valid) state <= pbfm_pkg::S_EXEC;
        pbfm_pkg::S_EXEC: if (exec_go) state <= pbfm_pkg::S_IDLE;
        default:          state <= pbfm_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == pbfm_pkg::S_IDLE && in_valid) begin
      act_q <= action;
      pid_q <= page_id;
      mk_q  <= mark_dirty;
    end
  end

  genvar i;
  generate
    for (i = 0; i < POOL_FRAMES; i++) begin : g_frame
      pbfm_fcell u_fcell (
        .clk      (clk),
        .rst      (rst),
        .key      (pid_q),
        .mod_sel  (exec_go && mod.en && (f_idx == FW'(i))),
        .mod      (mod),
        .load_sel (exec_go && ld.en && (ld_idx == FW'(i))),
        .load     (ld),
        .match    (c_match[i]),
        .valid    (c_valid[i]),
        .dirty    (c_dirty[i]),
        .pins     (c_pins[i]),
        .pid      (c_pid[i])
      );
    end
  endgenerate

  always_comb begin
    f_hit = 1'b0;
    f_idx = '0;
    for (int k = POOL_FRAMES - 1; k >= 0; k--) begin
      if (c_match[k]) begin
        f_hit = 1'b1;
        f_idx = FW'(k);
      end
    end
  end

  assign pins_f  = c_pins[f_idx];
  assign dirty_f = c_dirty[f_idx];
  assign pid_f   = c_pid[f_idx];

  pbfm_queue #(.N(POOL_FRAMES), .INIT_FULL(1'b1)) u_free (
    .clk      (clk),
    .rst      (rst),
    .key      (f_idx),
    .key_rm   (1'b0),
    .pop      (exec_go && fq_pop),
    .push     (exec_go && fq_push),
    .push_val (f_idx),
    .found    (free_found),
    .head     (free_head),
    .count    (free_cnt)
  );

  pbfm_queue #(.N(POOL_FRAMES), .INIT_FULL(1'b0)) u_lru (
    .clk      (clk),
    .rst      (rst),
    .key      (f_idx),
    .key_rm   (exec_go && lq_rm),
    .pop      (exec_go && lq_pop),
    .push     (exec_go && lq_push),
    .push_val (f_idx),
    .found    (lru_found),
    .head     (lru_head),
    .count    (lru_cnt)
  );

  // victim choice: free head, else the dropped frame itself, else LRU head
  assign drop      = (act_q == pbfm_pkg::ACT_NEW) && f_hit;
  assign from_free = (free_cnt != '0) || drop;
  assign take_ok   = from_free || (lru_cnt != '0);
  assign victim    = (free_cnt != '0) ? free_head : (drop ? f_idx : lru_head);
  assign vic_wb    = !from_free && c_dirty[lru_head];
  assign ld_idx    = victim;

  always_comb begin
    st      = pbfm_pkg::ST_OK;
    frm_idx = '0;
    o_hit   = 1'b0;
    o_wo    = 1'b0;
    o_wpid  = '0;
    o_load  = 1'b0;
    o_zero  = 1'b0;
    o_rel   = pbfm_pkg::REL_NONE;
    mod     = '0;
    ld      = '0;
    fq_pop  = 1'b0;
    fq_push = 1'b0;
    lq_rm   = 1'b0;
    lq_pop  = 1'b0;
    lq_push = 1'b0;
    case (act_q)
      pbfm_pkg::ACT_FETCH, pbfm_pkg::ACT_NEW: begin
        if (act_q == pbfm_pkg::ACT_FETCH && f_hit) begin
          frm_idx = f_idx;
          o_hit   = 1'b1;
          if (pins_f == pbfm_pkg::PIN_MAX) begin
            st = pbfm_pkg::ST_SAT;
          end else begin
            mod = '{en: 1'b1, valid: 1'b1, dirty: dirty_f, pins: pins_f + 8'd1};
            lq_rm = 1'b1;
          end
        end else begin
          if (drop) begin
            mod     = '{en: 1'b1, valid: 1'b0, dirty: 1'b0, pins: '0};
            lq_rm   = 1'b1;
            fq_push = (free_cnt != '0) && !free_found;
          end
          if (!take_ok) begin
            st = pbfm_pkg::ST_NOFRAME;
          end else begin
            ld.en    = 1'b1;
            ld.dirty = (act_q == pbfm_pkg::ACT_NEW);
            ld.pid   = pid_q;
            frm_idx  = victim;
            o_load   = (act_q == pbfm_pkg::ACT_FETCH);
            o_zero   = (act_q == pbfm_pkg::ACT_NEW);
            fq_pop   = (free_cnt != '0);
            lq_pop   = !from_free;
            o_wo     = vic_wb;
            o_wpid   = vic_wb ? c_pid[lru_head] : '0;
          end
        end
      end
      pbfm_pkg::ACT_UNPIN: begin
        if (!f_hit) begin
          st = pbfm_pkg::ST_NOTRES;
        end else begin
          frm_idx = f_idx;
          if (pins_f == '0) begin
            st = pbfm_pkg::ST_NOTPIN;
          end else begin
            mod = '{en: 1'b1, valid: 1'b1, dirty: dirty_f | mk_q, pins: pins_f - 8'd1};
            lq_push = (pins_f == PW'(1)) && !lru_found
                      && (lru_cnt < CW'(POOL_FRAMES));
          end
        end
      end
      pbfm_pkg::ACT_DELETE: begin
        if (!f_hit) begin
          o_rel = pbfm_pkg::REL_ZERO;
        end else begin
          frm_idx = f_idx;
          o_zero  = 1'b1;
          o_rel   = pbfm_pkg::REL_DEALLOC;
          mod     = '{en: 1'b1, valid: 1'b0, dirty: 1'b1, pins: '0};
          lq_rm   = 1'b1;
          fq_push = (free_cnt < CW'(POOL_FRAMES));
        end
      end
      pbfm_pkg::ACT_FLUSH: begin
        if (!f_hit) begin
          st = pbfm_pkg::ST_NOTRES;
        end else begin
          frm_idx = f_idx;
          o_wo    = 1'b1;
          o_wpid  = pid_f;
          mod     = '{en: 1'b1, valid: 1'b1, dirty: 1'b0, pins: pins_f};
        end
      end
      default: begin
      end
    endcase
  end

  assign frm_ext = {4'b0000, frm_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      status         <= st;
      frame          <= frm_ext[3:0];
      hit            <= o_hit;
      write_out      <= o_wo;
      write_page_id  <= o_wpid;
      load_from_disk <= o_load;
      zero_frame     <= o_zero;
      disk_release   <= o_rel;
    end
  end

endmodule
